// ===== design/euler_to_quaternion_macros.svh =====
// euler_to_quaternion_macros.svh: assertion macros for the Euler angle converter.
// Included by the top level; depends on a clock named clock and a reset named reset.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// same-cycle implication, off during reset
`define E2Q_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("e2q check failed");

// next-cycle implication, off during reset
`define E2Q_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("e2q check failed");

`endif

// ===== design/e2q_pkg.sv =====
// e2q_pkg: constants, Taylor divisor tables and fixed-point helpers for the
// Euler angle to quaternion converter. No dependencies.
package e2q_pkg;

   localparam int DEF_ANGLE_BITS = 16;
   localparam int DEF_QUAT_BITS  = 16;

   // internal fixed point: signed Q2.30
   localparam int FRAC_BITS = 30;
   localparam int TRIG_W    = 32;
   localparam int M_W       = 31;
   localparam int M2_W      = 32;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic signed [TRIG_W-1:0] ONE_Q30 = 32'sd1073741824;

   // Horner divisors of the cosine and sine series
   localparam int COS_TERMS = 7;
   localparam int SIN_TERMS = 6;
   localparam int COS_DIV [COS_TERMS] = '{182, 132, 90, 56, 30, 12, 2};
   localparam int SIN_DIV [SIN_TERMS] = '{156, 110, 72, 42, 20, 6};

   // pipeline depths
   localparam int CELL_STAGES = 3;
   localparam int PREP_STAGES = 3;
   localparam int SIN_DLY     = SIN_TERMS * CELL_STAGES;
   localparam int SIN_PAD     = (COS_TERMS - SIN_TERMS) * CELL_STAGES - 1;
   localparam int TRIG_STAGES = PREP_STAGES + COS_TERMS * CELL_STAGES;
   localparam int CMB_STAGES  = 4;
   localparam int PIPE_DEPTH  = TRIG_STAGES + CMB_STAGES;

   // Q2.30 product truncated toward zero
   function automatic logic signed [TRIG_W-1:0] qtrunc(input logic signed [63:0] p);
      logic signed [63:0] sh;
      sh = p >>> FRAC_BITS;
      if (p[63] && (p[FRAC_BITS-1:0] != '0)) begin
         sh = sh + 64'sd1;
      end
      return sh[TRIG_W-1:0];
   endfunction

endpackage

// ===== design/e2q_horner_cell.sv =====
// e2q_horner_cell: one Horner step t' = 1 - m2*t/DIV of a Taylor series in Q2.30.
// Depends on e2q_pkg. Three register stages: multiply, reciprocal, correct.
module e2q_horner_cell
   import e2q_pkg::*;
#(
   parameter int DIV = 2
) (
   input  logic                     clock,
   input  logic                     ce,
   input  logic [M2_W-1:0]          m2_in,
   input  logic signed [TRIG_W-1:0] t_in,
   output logic [M2_W-1:0]          m2_out,
   output logic signed [TRIG_W-1:0] t_out
);

   localparam longint unsigned RECIP_L = (64'd1 << 32) / DIV;
   localparam logic [31:0] RECIP = 32'(RECIP_L);
   localparam logic [39:0] DIV_W = 40'(DIV);

   logic signed [64:0] prod_in, prod_ff;
   logic [M2_W-1:0]    m2_a_ff, m2_b_ff, m2_c_ff;
   logic [64:0]        abs_b;
   logic [31:0]        q_in, q_ff;
   logic [63:0]        est_full;
   logic [31:0]        est_in, est_ff;
   logic               neg_in, neg_ff;
   logic [39:0]        rem_c;
   logic [31:0]        quo_c;
   logic signed [32:0] t_wide;
   logic signed [TRIG_W-1:0] t_in_c, t_ff;

   // stage A: m2 * t
   assign prod_in = $signed({1'b0, m2_in}) * t_in;

   // stage B: magnitude over 2^30, then estimate the quotient by reciprocal
   always_comb begin
      neg_in   = prod_ff[64];
      abs_b    = neg_in ? (65'd0 - prod_ff) : prod_ff;
      q_in     = abs_b[61:30];
      est_full = 64'(q_in) * 64'(RECIP);
      est_in   = est_full[63:32];
   end

   // stage C: correct the estimate by one, form the next term
   always_comb begin
      rem_c  = 40'(q_ff) - 40'(est_ff) * DIV_W;
      quo_c  = est_ff + ((rem_c >= DIV_W) ? 32'd1 : 32'd0);
      t_wide = neg_ff ? (33'(ONE_Q30) + $signed({1'b0, quo_c}))
                      : (33'(ONE_Q30) - $signed({1'b0, quo_c}));
      t_in_c = t_wide[TRIG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         prod_ff <= prod_in;
         m2_a_ff <= m2_in;
         q_ff    <= q_in;
         est_ff  <= est_in;
         neg_ff  <= neg_in;
         m2_b_ff <= m2_a_ff;
         t_ff    <= t_in_c;
         m2_c_ff <= m2_b_ff;
      end
   end

   assign m2_out = m2_c_ff;
   assign t_out  = t_ff;

endmodule

// ===== design/e2q_half_trig.sv =====
// e2q_half_trig: cosine and sine of half a binary angle in Q2.30.
// Depends on e2q_pkg and e2q_horner_cell; two chains of Horner cells.
module e2q_half_trig
   import e2q_pkg::*;
#(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
   input  logic                     clock,
   input  logic                     ce,
   input  logic [ANGLE_BITS-1:0]    angle,
   output logic signed [TRIG_W-1:0] cos_out,
   output logic signed [TRIG_W-1:0] sin_out
);

   logic [ANGLE_BITS-1:0]    mag_ff;
   logic                     neg0_ff, neg1_ff, neg2_ff;
   logic [ANGLE_BITS+31:0]   mprod;
   logic [M_W-1:0]           m_ff, mq_ff;
   logic [61:0]              msq;
   logic [M2_W-1:0]          m2_ff;
   logic [M_W:0]             nm_dly_ff [SIN_DLY];
   logic signed [63:0]       sprod;
   logic signed [TRIG_W-1:0] sv, s_in, s_ff;
   logic signed [TRIG_W-1:0] s_pad_ff [SIN_PAD];

   logic [M2_W-1:0]          cos_m2 [COS_TERMS+1];
   logic signed [TRIG_W-1:0] cos_t  [COS_TERMS+1];
   logic [M2_W-1:0]          sin_m2 [SIN_TERMS+1];
   logic signed [TRIG_W-1:0] sin_t  [SIN_TERMS+1];

   assign mprod = (ANGLE_BITS+32)'(mag_ff) * (ANGLE_BITS+32)'(PI_Q30);
   assign msq   = 62'(m_ff) * 62'(m_ff);

   // prepare: magnitude, half angle in radians, its square
   always_ff @(posedge clock) begin
      if (ce) begin
         neg0_ff <= angle[ANGLE_BITS-1];
         mag_ff  <= angle[ANGLE_BITS-1] ? (ANGLE_BITS'(0) - angle) : angle;
         neg1_ff <= neg0_ff;
         m_ff    <= mprod[ANGLE_BITS+M_W-1:ANGLE_BITS];
         neg2_ff <= neg1_ff;
         mq_ff   <= m_ff;
         m2_ff   <= msq[61:30];
      end
   end

   assign cos_m2[0] = m2_ff;
   assign cos_t[0]  = ONE_Q30;
   assign sin_m2[0] = m2_ff;
   assign sin_t[0]  = ONE_Q30;

   // cosine chain
   for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
      e2q_horner_cell #(.DIV(COS_DIV[i])) u_cell (
         .clock (clock),
         .ce    (ce),
         .m2_in (cos_m2[i]),
         .t_in  (cos_t[i]),
         .m2_out(cos_m2[i+1]),
         .t_out (cos_t[i+1])
      );
   end

   // sine chain
   for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
      e2q_horner_cell #(.DIV(SIN_DIV[i])) u_cell (
         .clock (clock),
         .ce    (ce),
         .m2_in (sin_m2[i]),
         .t_in  (sin_t[i]),
         .m2_out(sin_m2[i+1]),
         .t_out (sin_t[i+1])
      );
   end

   // carry sign and half angle beside the sine chain
   always_ff @(posedge clock) begin
      if (ce) begin
         nm_dly_ff[0] <= {neg2_ff, mq_ff};
         for (int k = 1; k < SIN_DLY; k++) begin
            nm_dly_ff[k] <= nm_dly_ff[k-1];
         end
      end
   end

   // sine = m * series, signed by the angle
   always_comb begin
      sprod = $signed({1'b0, nm_dly_ff[SIN_DLY-1][M_W-1:0]}) * sin_t[SIN_TERMS];
      sv    = qtrunc(sprod);
      s_in  = nm_dly_ff[SIN_DLY-1][M_W] ? (TRIG_W'(0) - sv) : sv;
   end

   // align sine with the longer cosine chain
   always_ff @(posedge clock) begin
      if (ce) begin
         s_ff        <= s_in;
         s_pad_ff[0] <= s_ff;
         for (int k = 1; k < SIN_PAD; k++) begin
            s_pad_ff[k] <= s_pad_ff[k-1];
         end
      end
   end

   assign cos_out = cos_t[COS_TERMS];
   assign sin_out = s_pad_ff[SIN_PAD-1];

endmodule

// ===== design/e2q_combine.sv =====
// e2q_combine: products of the half-angle cosines and sines, sums, rounding
// and saturation to signed Q1.(QUAT_BITS-1). Depends on e2q_pkg.
module e2q_combine
   import e2q_pkg::*;
#(
   parameter int QUAT_BITS = DEF_QUAT_BITS
) (
   input  logic                        clock,
   input  logic                        ce,
   input  logic signed [TRIG_W-1:0]    c1,
   input  logic signed [TRIG_W-1:0]    s1,
   input  logic signed [TRIG_W-1:0]    c2,
   input  logic signed [TRIG_W-1:0]    s2,
   input  logic signed [TRIG_W-1:0]    c3,
   input  logic signed [TRIG_W-1:0]    s3,
   output logic signed [QUAT_BITS-1:0] quat_w,
   output logic signed [QUAT_BITS-1:0] quat_x,
   output logic signed [QUAT_BITS-1:0] quat_y,
   output logic signed [QUAT_BITS-1:0] quat_z
);

   localparam logic [65:0] HALF  = 66'd1 << (FRAC_BITS - 1);
   localparam logic [65:0] LIMP  = (66'd1 << (QUAT_BITS - 1)) - 66'd1;
   localparam logic [65:0] LIMN  = 66'd1 << (QUAT_BITS - 1);
   localparam logic signed [QUAT_BITS-1:0] QMAX = QUAT_BITS'(LIMP);
   localparam logic signed [QUAT_BITS-1:0] QMIN = QUAT_BITS'(LIMN);

   logic signed [TRIG_W-1:0] c1c2_ff, s1s2_ff, s1c2_ff, c1s2_ff, c3_ff, s3_ff;
   logic signed [TRIG_W-1:0] wa_ff, wb_ff, xa_ff, xb_ff, ya_ff, yb_ff, za_ff, zb_ff;
   logic signed [32:0]       w_ff, x_ff, y_ff, z_ff;
   logic signed [QUAT_BITS-1:0] qw_ff, qx_ff, qy_ff, qz_ff;

   // round half away from zero and saturate
   function automatic logic signed [QUAT_BITS-1:0] to_quat(input logic signed [32:0] v);
      logic [32:0] mag;
      logic [65:0] rmag;
      logic signed [QUAT_BITS-1:0] res;
      mag  = v[32] ? (33'd0 - v) : v;
      rmag = ((66'(mag) << (QUAT_BITS - 1)) + HALF) >> FRAC_BITS;
      if (v[32]) begin
         res = (rmag > LIMN) ? QMIN : QUAT_BITS'(66'd0 - rmag);
      end else begin
         res = (rmag > LIMP) ? QMAX : QUAT_BITS'(rmag);
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (ce) begin
         // pair products
         c1c2_ff <= qtrunc(64'(c1) * 64'(c2));
         s1s2_ff <= qtrunc(64'(s1) * 64'(s2));
         s1c2_ff <= qtrunc(64'(s1) * 64'(c2));
         c1s2_ff <= qtrunc(64'(c1) * 64'(s2));
         c3_ff   <= c3;
         s3_ff   <= s3;
         // triple products
         wa_ff <= qtrunc(64'(c1c2_ff) * 64'(c3_ff));
         wb_ff <= qtrunc(64'(s1s2_ff) * 64'(s3_ff));
         xa_ff <= qtrunc(64'(c1c2_ff) * 64'(s3_ff));
         xb_ff <= qtrunc(64'(s1s2_ff) * 64'(c3_ff));
         ya_ff <= qtrunc(64'(s1c2_ff) * 64'(c3_ff));
         yb_ff <= qtrunc(64'(c1s2_ff) * 64'(s3_ff));
         za_ff <= qtrunc(64'(c1s2_ff) * 64'(c3_ff));
         zb_ff <= qtrunc(64'(s1c2_ff) * 64'(s3_ff));
         // sums
         w_ff <= 33'(wa_ff) - 33'(wb_ff);
         x_ff <= 33'(xa_ff) + 33'(xb_ff);
         y_ff <= 33'(ya_ff) + 33'(yb_ff);
         z_ff <= 33'(za_ff) - 33'(zb_ff);
         // output scaling
         qw_ff <= to_quat(w_ff);
         qx_ff <= to_quat(x_ff);
         qy_ff <= to_quat(y_ff);
         qz_ff <= to_quat(z_ff);
      end
   end

   assign quat_w = qw_ff;
   assign quat_x = qx_ff;
   assign quat_y = qy_ff;
   assign quat_z = qz_ff;

endmodule

// ===== design/euler_to_quaternion.sv =====
// Euler angle to quaternion converter: heading, attitude and bank (binary angles, full scale
// = pi) in, unit quaternion w, x, y, z in saturated signed Q1.(QUAT_BITS-1) out. It accepts
// one transaction per clock while no result is stalled; each result passes the prepare stages,
// the cosine chain of seven Horner cells at three stages each, and the combine stages. The whole
// pipeline holds while a result waits on rsp_tready. No state is kept between transactions.
// Depends on e2q_pkg, e2q_half_trig, e2q_combine and euler_to_quaternion_macros.svh.
`include "euler_to_quaternion_macros.svh"

module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS,
   parameter int QUAT_BITS  = DEF_QUAT_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // heading, attitude, bank from the lowest bit up
   input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // quat_w, quat_x, quat_y, quat_z from the lowest bit up
   output logic [((4*QUAT_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int OUT_W = ((4*QUAT_BITS+7)/8)*8;

   logic                        pipe_ce;
   logic [PIPE_DEPTH-1:0]       valid_ff, valid_in;
   logic signed [TRIG_W-1:0]    c1, s1, c2, s2, c3, s3;
   logic signed [QUAT_BITS-1:0] qw, qx, qy, qz;

   // advance unless a finished result is stalled
   assign pipe_ce    = !valid_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = pipe_ce;
   assign valid_in   = {valid_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_ce) begin
         valid_ff <= valid_in;
      end
   end

   e2q_half_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_heading (
      .clock  (clock),
      .ce     (pipe_ce),
      .angle  (req_tdata[ANGLE_BITS-1:0]),
      .cos_out(c1),
      .sin_out(s1)
   );

   e2q_half_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_attitude (
      .clock  (clock),
      .ce     (pipe_ce),
      .angle  (req_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
      .cos_out(c2),
      .sin_out(s2)
   );

   e2q_half_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_bank (
      .clock  (clock),
      .ce     (pipe_ce),
      .angle  (req_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
      .cos_out(c3),
      .sin_out(s3)
   );

   e2q_combine #(.QUAT_BITS(QUAT_BITS)) u_combine (
      .clock (clock),
      .ce    (pipe_ce),
      .c1    (c1),
      .s1    (s1),
      .c2    (c2),
      .s2    (s2),
      .c3    (c3),
      .s3    (s3),
      .quat_w(qw),
      .quat_x(qx),
      .quat_y(qy),
      .quat_z(qz)
   );

   assign rsp_tvalid = valid_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = OUT_W'({qz, qy, qx, qw});

   // a held pipeline keeps its occupancy
   `E2Q_ASSERT_NEXT(a_hold_keeps_valid, !pipe_ce, $stable(valid_ff))
   // a stalled result is never dropped
   `E2Q_ASSERT_NEXT(a_stall_keeps_rsp, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // an empty output stage never blocks the input
   `E2Q_ASSERT_SAME(a_ready_when_empty, !rsp_tvalid, req_tready)

endmodule
